### sv/emap_pkg.sv
package emap_pkg;

   localparam int ROWS = 16;
   localparam int COLS = 16;
   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLS);
   localparam int HALF_ROWS = (ROWS + 1) / 2;
   localparam int HALF_COLS = (COLS + 1) / 2;
   localparam int BANK_DEPTH = HALF_ROWS * HALF_COLS;
   localparam int BANK_AW = $clog2(BANK_DEPTH);
   localparam int BANKS = 4;

   localparam int FIELD_ROW_W = 4;
   localparam int FIELD_COL_W = 4;
   localparam int ENTRY_W = 16;
   localparam int DATA_W = 24;
   localparam int CFG_W = 24;
   localparam int POS_W = 48;
   localparam int FRAC_W = 16;
   localparam int INTERP_W = 32;
   localparam int VALUE_W = 39;

   localparam logic [POS_W-1:0] POS_TOP_R = POS_W'((ROWS - 1) * 65536 - 1);
   localparam logic [POS_W-1:0] POS_TOP_C = POS_W'((COLS - 1) * 65536 - 1);

   localparam int OUT_DEPTH = 16;
   localparam int OUT_AW = $clog2(OUT_DEPTH);
   localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_SCALE = 3'd4;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic penalized;
   } rsp_item_type;

   function automatic logic [BANK_AW-1:0] bank_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
      return BANK_AW'(int'(r >> 1) * HALF_COLS + int'(c >> 1));
   endfunction

endpackage

### sv/emap_if.sv
interface emap_req_if;
   import emap_pkg::*;
   logic valid;
   logic ready;
   logic func;
   logic [FIELD_ROW_W-1:0] row;
   logic [FIELD_COL_W-1:0] col;
   logic [ENTRY_W-1:0] entry;
   logic [DATA_W-1:0] speed;
   logic [DATA_W-1:0] pressure;
   modport source(output valid, func, row, col, entry, speed, pressure, input ready);
   modport sink(input valid, func, row, col, entry, speed, pressure, output ready);
endinterface

interface emap_rsp_if;
   import emap_pkg::*;
   logic valid;
   logic ready;
   logic [VALUE_W-1:0] value;
   logic penalized;
   modport source(output valid, value, penalized, input ready);
   modport sink(input valid, value, penalized, output ready);
endinterface

### sv/emap_ram.sv
module emap_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input logic clock,
   input logic we,
   input logic [$clog2(DEPTH)-1:0] waddr,
   input logic [WIDTH-1:0] wdata,
   input logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

### sv/emap_out_fifo.sv
module emap_out_fifo (
   input logic clock,
   input logic reset,
   input logic push,
   input emap_pkg::rsp_item_type push_item,
   emap_rsp_if.source rsp
);
   import emap_pkg::*;

   rsp_item_type mem_ff [OUT_DEPTH];
   logic [OUT_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_CW-1:0] count_ff, count_in;
   logic pop;

   assign pop = rsp.valid && rsp.ready;
   assign rsp.valid = (count_ff != '0);
   assign rsp.value = mem_ff[rd_ptr_ff].value;
   assign rsp.penalized = mem_ff[rd_ptr_ff].penalized;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

### sv/engine_map_bilinear_lookup.sv
// Engine-map lookup with bilinear interpolation over a 16 by 16 table of 16-bit words.
// Requests arrive on req_ch. A request with func low writes one table word at row and
// col; a request with func high looks up speed and pressure and returns the Q16.16
// interpolated word, multiplied by 100 and flagged as penalized when the speed lies
// outside the configured range. Every request yields exactly one response on rsp_ch,
// in request order; write requests answer with zero.
// The csr_ port writes the five range and scale registers; the user must do so only
// while the block is idle, which the block itself does not enforce. An accepted
// request passes through stages s1 to s6. One request is accepted per cycle while
// req_ch.ready is high: the table is split into four banks by row and column parity,
// so the four neighbor words come from four memory ports in the same cycle. A 16-entry
// output queue holds finished responses; req_ch.ready drops once 16 requests are in
// flight or waiting, so a stalled receiver stops intake without losing results.
// Reset is synchronous and clears the pipeline, the queue and the registers to their
// defaults. The table contents are undefined after reset until written.
module engine_map_bilinear_lookup (
   input logic clock,
   input logic reset,
   emap_req_if.sink req_ch,
   emap_rsp_if.source rsp_ch,
   input logic csr_we,
   input logic [emap_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [emap_pkg::CFG_W-1:0] csr_wdata
);
   import emap_pkg::*;

   logic [CFG_W-1:0] speed_min_ff, speed_max_ff, pressure_min_ff;
   logic [CFG_W-1:0] speed_scale_ff, pressure_scale_ff;

   logic [OUT_CW-1:0] inflight_ff, inflight_in;
   logic req_take, rsp_take;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   logic s1_func_ff;
   logic [FIELD_ROW_W-1:0] s1_row_ff;
   logic [FIELD_COL_W-1:0] s1_col_ff;
   logic [ENTRY_W-1:0] s1_entry_ff;
   logic [DATA_W-1:0] s1_speed_ff, s1_pressure_ff;

   logic s2_func_ff, s2_pen_ff;
   logic [FIELD_ROW_W-1:0] s2_row_ff;
   logic [FIELD_COL_W-1:0] s2_col_ff;
   logic [ENTRY_W-1:0] s2_entry_ff;
   logic [DATA_W-1:0] s2_off_r_ff, s2_off_c_ff;
   logic [DATA_W-1:0] off_r_in, off_c_in;
   logic pen_in;

   logic s3_func_ff, s3_pen_ff;
   logic [FIELD_ROW_W-1:0] s3_row_ff;
   logic [FIELD_COL_W-1:0] s3_col_ff;
   logic [ENTRY_W-1:0] s3_entry_ff;
   logic [POS_W-1:0] s3_pos_r_ff, s3_pos_c_ff;

   logic [POS_W-1:0] pos_r, pos_c;
   logic [ROW_W-1:0] look_i;
   logic [COL_W-1:0] look_j;
   logic [ROW_W-1:0] wr_row;
   logic [COL_W-1:0] wr_col;
   logic wr_ok;
   logic [BANK_AW-1:0] wr_addr;

   logic [BANKS-1:0] bank_we;
   logic [BANK_AW-1:0] bank_raddr [BANKS];
   logic [ENTRY_W-1:0] bank_q [BANKS];

   logic s4_func_ff, s4_pen_ff, s4_i0_ff, s4_j0_ff;
   logic [FRAC_W-1:0] s4_wr_ff, s4_wc_ff;
   logic [ENTRY_W-1:0] t00, t01, t10, t11;
   logic signed [ENTRY_W:0] near_diff, far_diff;
   logic signed [33:0] near_prod, far_prod, near_sum, far_sum;

   logic s5_func_ff, s5_pen_ff;
   logic [FRAC_W-1:0] s5_wr_ff;
   logic [INTERP_W-1:0] s5_near_ff, s5_far_ff;
   logic signed [INTERP_W:0] vert_diff;
   logic signed [49:0] vert_prod, vert_sum;

   logic s6_func_ff, s6_pen_ff;
   logic [INTERP_W-1:0] s6_interp_ff;
   logic [VALUE_W-1:0] interp_ext, interp_x100;
   rsp_item_type push_item;

   assign req_take = req_ch.valid && req_ch.ready;
   assign rsp_take = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (inflight_ff < OUT_CW'(OUT_DEPTH));

   always_comb begin
      inflight_in = inflight_ff;
      if (req_take && !rsp_take) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_min_ff <= '0;
         speed_max_ff <= '1;
         pressure_min_ff <= '0;
         speed_scale_ff <= CFG_W'(65536);
         pressure_scale_ff <= CFG_W'(65536);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPEED_MIN: speed_min_ff <= csr_wdata;
            CSR_SPEED_MAX: speed_max_ff <= csr_wdata;
            CSR_PRESSURE_MIN: pressure_min_ff <= csr_wdata;
            CSR_SPEED_SCALE: speed_scale_ff <= csr_wdata;
            CSR_PRESSURE_SCALE: pressure_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         inflight_ff <= inflight_in;
         v1_ff <= req_take;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_comb begin
      off_r_in = (s1_speed_ff > speed_min_ff) ? s1_speed_ff - speed_min_ff : '0;
      off_c_in = (s1_pressure_ff > pressure_min_ff) ? s1_pressure_ff - pressure_min_ff : '0;
      pen_in = (s1_speed_ff < speed_min_ff) || (s1_speed_ff > speed_max_ff);
   end

   always_comb begin
      pos_r = (s3_pos_r_ff > POS_TOP_R) ? POS_TOP_R : s3_pos_r_ff;
      pos_c = (s3_pos_c_ff > POS_TOP_C) ? POS_TOP_C : s3_pos_c_ff;
      look_i = pos_r[FRAC_W +: ROW_W];
      look_j = pos_c[FRAC_W +: COL_W];
      wr_row = ROW_W'(s3_row_ff);
      wr_col = COL_W'(s3_col_ff);
      wr_ok = (int'(s3_row_ff) < ROWS) && (int'(s3_col_ff) < COLS);
      wr_addr = bank_addr(wr_row, wr_col);
   end

   // Bank b holds the words whose row parity is b[1] and column parity is b[0].
   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      localparam logic ROW_PAR = 1'(b / 2);
      localparam logic COL_PAR = 1'(b % 2);
      logic [ROW_W-1:0] look_r;
      logic [COL_W-1:0] look_c;

      assign look_r = (look_i[0] == ROW_PAR) ? look_i : look_i + 1'b1;
      assign look_c = (look_j[0] == COL_PAR) ? look_j : look_j + 1'b1;
      assign bank_raddr[b] = bank_addr(look_r, look_c);
      assign bank_we[b] = v3_ff && (s3_func_ff == FUNC_WRITE) && wr_ok
                          && (wr_row[0] == ROW_PAR) && (wr_col[0] == COL_PAR);

      emap_ram #(
         .WIDTH(ENTRY_W),
         .DEPTH(BANK_DEPTH)
      ) u_bank (
         .clock(clock),
         .we(bank_we[b]),
         .waddr(wr_addr),
         .wdata(s3_entry_ff),
         .raddr(bank_raddr[b]),
         .rdata(bank_q[b])
      );
   end

   always_comb begin
      t00 = bank_q[{s4_i0_ff, s4_j0_ff}];
      t01 = bank_q[{s4_i0_ff, ~s4_j0_ff}];
      t10 = bank_q[{~s4_i0_ff, s4_j0_ff}];
      t11 = bank_q[{~s4_i0_ff, ~s4_j0_ff}];
      near_diff = $signed({1'b0, t01}) - $signed({1'b0, t00});
      far_diff = $signed({1'b0, t11}) - $signed({1'b0, t10});
      near_prod = $signed({1'b0, s4_wc_ff}) * near_diff;
      far_prod = $signed({1'b0, s4_wc_ff}) * far_diff;
      near_sum = $signed({2'b00, t00, 16'h0000}) + near_prod;
      far_sum = $signed({2'b00, t10, 16'h0000}) + far_prod;
   end

   always_comb begin
      vert_diff = $signed({1'b0, s5_far_ff}) - $signed({1'b0, s5_near_ff});
      vert_prod = $signed({1'b0, s5_wr_ff}) * vert_diff;
      vert_sum = $signed({2'b00, s5_near_ff, 16'h0000}) + vert_prod;
   end

   always_comb begin
      interp_ext = VALUE_W'(s6_interp_ff);
      interp_x100 = (interp_ext << 6) + (interp_ext << 5) + (interp_ext << 2);
      push_item.value = '0;
      push_item.penalized = 1'b0;
      if (s6_func_ff == FUNC_LOOKUP) begin
         push_item.value = s6_pen_ff ? interp_x100 : interp_ext;
         push_item.penalized = s6_pen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff <= req_ch.func;
         s1_row_ff <= req_ch.row;
         s1_col_ff <= req_ch.col;
         s1_entry_ff <= req_ch.entry;
         s1_speed_ff <= req_ch.speed;
         s1_pressure_ff <= req_ch.pressure;
      end
      s2_func_ff <= s1_func_ff;
      s2_row_ff <= s1_row_ff;
      s2_col_ff <= s1_col_ff;
      s2_entry_ff <= s1_entry_ff;
      s2_off_r_ff <= off_r_in;
      s2_off_c_ff <= off_c_in;
      s2_pen_ff <= pen_in;

      s3_func_ff <= s2_func_ff;
      s3_row_ff <= s2_row_ff;
      s3_col_ff <= s2_col_ff;
      s3_entry_ff <= s2_entry_ff;
      s3_pen_ff <= s2_pen_ff;
      s3_pos_r_ff <= s2_off_r_ff * speed_scale_ff;
      s3_pos_c_ff <= s2_off_c_ff * pressure_scale_ff;

      s4_func_ff <= s3_func_ff;
      s4_pen_ff <= s3_pen_ff;
      s4_i0_ff <= look_i[0];
      s4_j0_ff <= look_j[0];
      s4_wr_ff <= pos_r[FRAC_W-1:0];
      s4_wc_ff <= pos_c[FRAC_W-1:0];

      s5_func_ff <= s4_func_ff;
      s5_pen_ff <= s4_pen_ff;
      s5_wr_ff <= s4_wr_ff;
      s5_near_ff <= near_sum[INTERP_W-1:0];
      s5_far_ff <= far_sum[INTERP_W-1:0];

      s6_func_ff <= s5_func_ff;
      s6_pen_ff <= s5_pen_ff;
      s6_interp_ff <= vert_sum[FRAC_W +: INTERP_W];
   end

   emap_out_fifo u_out_fifo (
      .clock(clock),
      .reset(reset),
      .push(v6_ff),
      .push_item(push_item),
      .rsp(rsp_ch)
   );
endmodule

### sv/emap_checker.sv
module emap_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [emap_pkg::VALUE_W-1:0] rsp_value,
   input logic rsp_penalized
);
   import emap_pkg::*;

   logic [OUT_CW:0] outstanding_ff, outstanding_in;
   logic req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_take && !rsp_take) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_invented_rsp: assert property (@(posedge clock) disable iff (reset)
      (outstanding_ff == '0) |-> !rsp_valid)
      else $error("response offered with no request outstanding");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (outstanding_ff == (OUT_CW + 1)'(OUT_DEPTH)) |-> !req_ready)
      else $error("request accepted beyond output queue capacity");

   a_stall_holds_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_value) && $stable(rsp_penalized)))
      else $error("stalled response changed or dropped");
endmodule

bind engine_map_bilinear_lookup emap_checker u_emap_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_value(rsp_ch.value),
   .rsp_penalized(rsp_ch.penalized)
);
